>>> rtl/core/ksca_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksca_pkg
// Shared types, constants and key table for the key scanner with click
// detection and autorepeat.
// -----------------------------------------------------------------------------
package ksca_pkg;

  // Field widths
  localparam int WORD_W      = 32;
  localparam int KEY_W       = 5;
  localparam int DELAY_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int TABLE_LEN   = 19;
  localparam int QUEUE_DEPTH = 2;

  // Defaults
  localparam int KEY_COUNT_DEF = 19;
  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd500;
  localparam logic [DELAY_W-1:0] NEXT_DELAY_RST  = 16'd175;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_DELAY  = 1'd1;

  // Request opcodes
  typedef enum logic {
    OP_SCAN   = 1'b0,
    OP_FORGET = 1'b1
  } opcode_t;

  // Key table: group select (1 = main word, 0 = low word) and mask
  localparam logic [TABLE_LEN-1:0] KEY_GROUP = 19'b00_11111111111111111;

  localparam logic [WORD_W-1:0] KEY_MASK [TABLE_LEN] = '{
    32'h4000_0000, 32'h2000_0000, 32'h1000_0000, 32'h0200_0000,
    32'h0100_0000, 32'h0020_0000, 32'h0010_0000, 32'h0008_0000,
    32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_4000,
    32'h0000_2000, 32'h0000_1000, 32'h0000_0800, 32'h0000_0040,
    32'h0000_0020, 32'h0000_0003, 32'h0000_0001
  };

  // Request after classification, queued between front and back
  typedef struct packed {
    opcode_t               opcode;
    logic [TABLE_LEN-1:0]  down;
    logic [KEY_W-1:0]      pressed;
    logic [KEY_W-1:0]      clicked;
    logic [WORD_W-1:0]     now_ms;
  } scan_item_t;

  // Delay settings
  typedef struct packed {
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] next_delay;
  } delay_cfg_t;

  // Which table entries take part for a given key count
  function automatic logic [TABLE_LEN-1:0] key_enable(input int count);
    logic [TABLE_LEN-1:0] en;
    en = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      en[i] = (i < count);
    end
    return en;
  endfunction

  // One bit per key: all mask bits low in its group's word
  function automatic logic [TABLE_LEN-1:0] key_down_vec(input logic [WORD_W-1:0] low_w,
                                                         input logic [WORD_W-1:0] main_w);
    logic [TABLE_LEN-1:0] v;
    v = '0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      v[i] = ((KEY_GROUP[i] ? main_w : low_w) & KEY_MASK[i]) == '0;
    end
    return v;
  endfunction

  // 1-based index of the lowest set bit, 0 when none
  function automatic logic [KEY_W-1:0] first_key(input logic [TABLE_LEN-1:0] v);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = TABLE_LEN - 1; i >= 0; i--) begin
      if (v[i]) k = KEY_W'(i + 1);
    end
    return k;
  endfunction

endpackage

>>> rtl/core/ksca_in_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksca_in_if
// Scan request channel: valid/ready handshake with opcode, status words and
// time stamp.
// -----------------------------------------------------------------------------
interface ksca_in_if;
  import ksca_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [WORD_W-1:0] status_low_word;
  logic [WORD_W-1:0] status_main_word;
  logic [WORD_W-1:0] now_ms;

  modport source (output valid, opcode, status_low_word, status_main_word, now_ms,
                  input ready);
  modport sink   (input valid, opcode, status_low_word, status_main_word, now_ms,
                  output ready);
endinterface

>>> rtl/core/ksca_out_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksca_out_if
// Result channel: valid/ready handshake with pressed, clicked and repeat keys.
// -----------------------------------------------------------------------------
interface ksca_out_if;
  import ksca_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] pressed_key;
  logic [KEY_W-1:0] clicked_key;
  logic [KEY_W-1:0] repeat_key;

  modport source (output valid, pressed_key, clicked_key, repeat_key, input ready);
  modport sink   (input valid, pressed_key, clicked_key, repeat_key, output ready);
endinterface

>>> rtl/core/ksca_front.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksca_front
// Accepts scan requests, decodes the key table against the new and previous
// status words and pushes the classified request into the queue.
// -----------------------------------------------------------------------------
module ksca_front #(
  parameter int KEY_COUNT = ksca_pkg::KEY_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ksca_in_if.sink                in_chan,
  output logic                   push_valid,
  input  logic                   push_ready,
  output ksca_pkg::scan_item_t   push_item
);
  import ksca_pkg::*;

  localparam int ACTIVE_KEYS = (KEY_COUNT < TABLE_LEN) ? KEY_COUNT : TABLE_LEN;
  localparam logic [TABLE_LEN-1:0] KEY_EN = key_enable(ACTIVE_KEYS);

  logic [WORD_W-1:0]    prev_low_r, prev_low_nxt;
  logic [WORD_W-1:0]    prev_main_r, prev_main_nxt;
  logic [TABLE_LEN-1:0] now_down;
  logic [TABLE_LEN-1:0] was_down;
  logic                 accept;
  opcode_t              op;

  assign op         = opcode_t'(in_chan.opcode);
  assign accept     = in_chan.valid && push_ready;
  assign push_valid = in_chan.valid;
  assign in_chan.ready = push_ready;

  // Key decode, current and previous scan
  assign now_down = key_down_vec(in_chan.status_low_word, in_chan.status_main_word) & KEY_EN;
  assign was_down = key_down_vec(prev_low_r, prev_main_r) & KEY_EN;

  always_comb begin
    push_item.opcode  = op;
    push_item.down    = now_down;
    push_item.pressed = first_key(now_down);
    push_item.clicked = first_key(now_down & ~was_down);
    push_item.now_ms  = in_chan.now_ms;
  end

  // Previous words follow every accepted scan, not a forget
  always_comb begin
    prev_low_nxt  = prev_low_r;
    prev_main_nxt = prev_main_r;
    if (accept && op == OP_SCAN) begin
      prev_low_nxt  = in_chan.status_low_word;
      prev_main_nxt = in_chan.status_main_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_low_r  <= '0;
      prev_main_r <= '0;
    end else begin
      prev_low_r  <= prev_low_nxt;
      prev_main_r <= prev_main_nxt;
    end
  end

endmodule

>>> rtl/core/ksca_fifo.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksca_fifo
// Short request queue between front and back so each side stalls on its own.
// -----------------------------------------------------------------------------
module ksca_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ksca_pkg::scan_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output ksca_pkg::scan_item_t pop_item
);
  import ksca_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  scan_item_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/core/ksca_back.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ksca_back
// Tracks the held key and event time, decides click and autorepeat events
// and registers the result for the output channel.
// -----------------------------------------------------------------------------
module ksca_back #(
  parameter int KEY_COUNT = ksca_pkg::KEY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  ksca_pkg::scan_item_t pop_item,
  input  ksca_pkg::delay_cfg_t cfg,
  ksca_out_if.source           out_chan
);
  import ksca_pkg::*;

  localparam int ACTIVE_KEYS = (KEY_COUNT < TABLE_LEN) ? KEY_COUNT : TABLE_LEN;

  logic [KEY_W-1:0]  held_key_r, held_key_nxt;
  logic [WORD_W-1:0] last_event_r, last_event_nxt;
  logic              repeating_r, repeating_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  pressed_r, pressed_nxt;
  logic [KEY_W-1:0]  clicked_r, clicked_nxt;
  logic [KEY_W-1:0]  repeat_r, repeat_nxt;

  logic              take;
  logic [31:0]       down_ext;
  logic              held_down;
  logic [WORD_W-1:0] diff;
  logic [DELAY_W-1:0] limit;
  logic              fire;

  assign pop_ready = !out_valid_r || out_chan.ready;
  assign take      = pop_valid && pop_ready;

  // Held key still pressed in this scan
  assign down_ext  = 32'(pop_item.down);
  assign held_down = (held_key_r != '0) && (held_key_r <= KEY_W'(ACTIVE_KEYS))
                     && down_ext[held_key_r - 1'b1];

  // Signed time since last event against the active delay
  assign diff  = pop_item.now_ms - last_event_r;
  assign limit = repeating_r ? cfg.next_delay : cfg.first_delay;
  assign fire  = !diff[WORD_W-1] && (diff > WORD_W'(limit));

  // Event decision and state update
  always_comb begin
    held_key_nxt   = held_key_r;
    last_event_nxt = last_event_r;
    repeating_nxt  = repeating_r;
    pressed_nxt    = pressed_r;
    clicked_nxt    = clicked_r;
    repeat_nxt     = repeat_r;
    out_valid_nxt  = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (take) begin
      out_valid_nxt = 1'b1;
      if (pop_item.opcode == OP_FORGET) begin
        held_key_nxt = '0;
        pressed_nxt  = '0;
        clicked_nxt  = '0;
        repeat_nxt   = '0;
      end else begin
        pressed_nxt = pop_item.pressed;
        clicked_nxt = pop_item.clicked;
        repeat_nxt  = '0;
        if (pop_item.clicked != '0) begin
          held_key_nxt   = pop_item.clicked;
          repeating_nxt  = 1'b0;
          last_event_nxt = pop_item.now_ms;
          repeat_nxt     = pop_item.clicked;
        end else if (held_down) begin
          if (fire) begin
            repeating_nxt  = 1'b1;
            last_event_nxt = pop_item.now_ms;
            repeat_nxt     = held_key_r;
          end
        end else begin
          held_key_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_key_r   <= '0;
      last_event_r <= '0;
      repeating_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      held_key_r   <= held_key_nxt;
      last_event_r <= last_event_nxt;
      repeating_r  <= repeating_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    pressed_r <= pressed_nxt;
    clicked_r <= clicked_nxt;
    repeat_r  <= repeat_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pressed_key = pressed_r;
  assign out_chan.clicked_key = clicked_r;
  assign out_chan.repeat_key  = repeat_r;

endmodule

>>> rtl/core/key_scan_click_autorepeat.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// key_scan_click_autorepeat
// Key scanner with click detection and autorepeat, top level.
// -----------------------------------------------------------------------------
// Takes one scan request per clock cycle while the queue has room and returns
// one result per request, in order. A result is offered on the output channel
// after its request passes the two-entry queue that decouples the front, which
// decodes the key table, from the back, and then the back's result register.
// The back updates the held key and event time once per accepted request, which
// sets the sustained rate of one request per cycle while the output is ready.
// The user writes the delay registers through the cfg_ port only at an idle moment;
// the block does not enforce this. They come out of reset at 500 ms and 175 ms.
module key_scan_click_autorepeat #(
  parameter int KEY_COUNT = ksca_pkg::KEY_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ksca_in_if.sink                          in_chan,
  ksca_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [ksca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ksca_pkg::DELAY_W-1:0]     cfg_wdata
);
  import ksca_pkg::*;

  delay_cfg_t cfg_r, cfg_nxt;
  logic       push_valid, push_ready;
  scan_item_t push_item;
  logic       pop_valid, pop_ready;
  scan_item_t pop_item;

  // Delay register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_DELAY: cfg_nxt.first_delay = cfg_wdata;
        CFG_NEXT_DELAY:  cfg_nxt.next_delay  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_delay <= FIRST_DELAY_RST;
      cfg_r.next_delay  <= NEXT_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ksca_front #(.KEY_COUNT(KEY_COUNT)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ksca_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ksca_back #(.KEY_COUNT(KEY_COUNT)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg       (cfg_r),
    .out_chan  (out_chan)
  );

endmodule
